// ===== rtl/qcr_pkg.sv =====
// Shared types and constants of the quantized convolution block.
package qcr_pkg;

    localparam logic [1:0] REQ_PIXEL   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT  = 2'd1;
    localparam logic [1:0] REQ_BIAS    = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [2:0] CFG_CHANNELS = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_WIDTH    = 3'd2;
    localparam logic [2:0] CFG_KERNELS  = 3'd3;
    localparam logic [2:0] CFG_PAD      = 3'd4;
    localparam logic [2:0] CFG_STRIDE   = 3'd5;
    localparam logic [2:0] CFG_FLAGS    = 3'd6;
    localparam logic [2:0] CFG_OFFSET   = 3'd7;

    localparam logic [7:0] WEIGHT_ZERO = 8'd127;
    localparam logic [8:0] BYTE_MAX    = 9'd255;

    typedef struct packed {
        logic [4:0] in_channels;
        logic [5:0] in_height;
        logic [5:0] in_width;
        logic [4:0] num_kernels;
        logic [2:0] pad_amount;
        logic [3:0] stride_step;
        logic [1:0] post_flags;
        logic [7:0] output_offset;
    } cfg_t;

endpackage

// ===== rtl/quantized_conv2d_requant.sv =====
// Top level of the quantized convolution block with requantization.
//
// s_axis carries request words: pixel, weight and bias loads, and compute
// requests. Loads are written into on-chip memories when their address is in
// range and give no result. A compute request gives one m_axis word holding the
// clamped output byte and the dimension error flag.
// A compute request passes through the check, accumulate, drain, post and
// output states, or from check straight to output when the error flag is
// set. While accumulating it walks every kernel tap and channel with one
// multiply and accumulate per cycle, fed by registered memory reads. The
// next word is taken in the cycle after the result is.
// One request is worked on at a time; s_axis_tready is low while a compute
// request is running or while its result waits in the output register.
// A stalled receiver holds the result word stable until it is taken.
// Reset returns the registers to their defaults and the control to idle;
// the memories keep their contents and are undefined until written.
// The cfg channel writes one register per word and is always ready; the
// user must write it only while the block is idle; the block does not enforce it.
module quantized_conv2d_requant
#(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_DIM      = 32,
    parameter int MAX_KERNELS  = 16,
    parameter int KERNEL_ROWS  = 3,
    parameter int KERNEL_COLS  = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // load_addr[13:0], data_byte[21:14], bias_value[53:22], shift_amount[58:54],
    // kernel_sel[62:59], out_row[68:63], out_col[74:69], zero fill
    input  logic [79:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_value[7:0]
    output logic [7:0]  m_axis_tdata,
    // dim_error[0]
    output logic        m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int PIX_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNELS * KERNEL_ROWS * KERNEL_COLS;
    localparam int PA = $clog2(PIX_DEPTH);
    localparam int WA = $clog2(WGT_DEPTH);
    localparam int KA = (MAX_KERNELS > 1) ? $clog2(MAX_KERNELS) : 1;
    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int RW = $clog2(KERNEL_ROWS + 1);
    localparam int SW = $clog2(KERNEL_COLS + 1);

    qcr_pkg::cfg_t cfg;

    qcr_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic [13:0] load_addr;
    logic [7:0]  data_byte;
    logic [31:0] bias_value;
    logic [4:0]  shift_amount;
    logic [3:0]  kernel_sel;
    logic [5:0]  out_row;
    logic [5:0]  out_col;

    assign load_addr    = s_axis_tdata[13:0];
    assign data_byte    = s_axis_tdata[21:14];
    assign bias_value   = s_axis_tdata[53:22];
    assign shift_amount = s_axis_tdata[58:54];
    assign kernel_sel   = s_axis_tdata[62:59];
    assign out_row      = s_axis_tdata[68:63];
    assign out_col      = s_axis_tdata[74:69];

    typedef enum logic [5:0]
    {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_MAC   = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_POST  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  pixel_mem  [PIX_DEPTH];
    logic [7:0]  weight_mem [WGT_DEPTH];
    logic [31:0] bias_mem   [MAX_KERNELS];
    logic [4:0]  shift_mem  [MAX_KERNELS];

    logic [3:0]  k_reg;
    logic [5:0]  row_reg, col_reg;
    logic [CW-1:0] c_reg;
    logic [RW-1:0] r_reg;
    logic [SW-1:0] s_reg;
    logic [31:0] acc_reg;
    logic [7:0]  pix_q_reg, wgt_q_reg;
    logic        rd_valid_reg, inside_q_reg;
    logic        err_reg;
    logic [31:0] bias_q_reg;
    logic [4:0]  shift_q_reg;
    logic [7:0]  res_reg;
    logic        valid_reg;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE) && !valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Output size and dimension checks. A position lies inside the output
    // when its window start does not pass the last padded start position.
    logic [7:0] ph, pw;
    logic [9:0] row_span, col_span;
    logic       cfg_bad, req_bad;
    always_comb
    begin
        ph = 8'(cfg.in_height) + 8'({cfg.pad_amount, 1'b0}) - 8'(KERNEL_ROWS);
        pw = 8'(cfg.in_width) + 8'({cfg.pad_amount, 1'b0}) - 8'(KERNEL_COLS);
        row_span = 10'(row_reg) * 10'(cfg.stride_step);
        col_span = 10'(col_reg) * 10'(cfg.stride_step);
        cfg_bad = (cfg.in_channels == 5'd0) || (cfg.num_kernels == 5'd0)
               || (cfg.stride_step == 4'd0)
               || (32'(cfg.in_height) < 32'(KERNEL_ROWS))
               || (32'(cfg.in_width) < 32'(KERNEL_COLS))
               || (32'(cfg.in_channels) > 32'(MAX_CHANNELS))
               || (32'(cfg.num_kernels) > 32'(MAX_KERNELS))
               || (32'(cfg.in_height) > 32'(MAX_DIM))
               || (32'(cfg.in_width) > 32'(MAX_DIM));
        req_bad = (5'(k_reg) >= cfg.num_kernels) || (row_span > 10'(ph))
               || (col_span > 10'(pw));
    end

    // Tap position for the current read.
    logic signed [15:0] y_pos, x_pos;
    logic               tap_in;
    logic [31:0]        pix_addr, wgt_addr;
    logic               last_step;
    always_comb
    begin
        y_pos = 16'(row_reg) * 16'(cfg.stride_step) + 16'(r_reg) - 16'(cfg.pad_amount);
        x_pos = 16'(col_reg) * 16'(cfg.stride_step) + 16'(s_reg) - 16'(cfg.pad_amount);
        tap_in = (y_pos >= 0) && (y_pos < $signed(16'(cfg.in_height)))
              && (x_pos >= 0) && (x_pos < $signed(16'(cfg.in_width)));
        pix_addr = (32'(c_reg) * 32'(MAX_DIM) + 32'(y_pos[7:0])) * 32'(MAX_DIM)
                 + 32'(x_pos[7:0]);
        wgt_addr = ((32'(k_reg) * 32'(MAX_CHANNELS) + 32'(c_reg)) * 32'(KERNEL_ROWS)
                 + 32'(r_reg)) * 32'(KERNEL_COLS) + 32'(s_reg);
        last_step = (5'(c_reg) == cfg.in_channels - 5'd1)
                 && (32'(r_reg) == 32'(KERNEL_ROWS - 1))
                 && (32'(s_reg) == 32'(KERNEL_COLS - 1));
    end

    // Memories: writes from loads, reads during accumulation.
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == qcr_pkg::REQ_PIXEL && 32'(load_addr) < PIX_DEPTH)
            pixel_mem[load_addr[PA-1:0]] <= data_byte;
        if (accept && s_axis_tuser == qcr_pkg::REQ_WEIGHT && 32'(load_addr) < WGT_DEPTH)
            weight_mem[load_addr[WA-1:0]] <= data_byte;
        if (accept && s_axis_tuser == qcr_pkg::REQ_BIAS && 32'(load_addr) < MAX_KERNELS)
        begin
            bias_mem[load_addr[KA-1:0]]  <= bias_value;
            shift_mem[load_addr[KA-1:0]] <= shift_amount;
        end
        pix_q_reg   <= pixel_mem[pix_addr[PA-1:0]];
        wgt_q_reg   <= weight_mem[wgt_addr[WA-1:0]];
        bias_q_reg  <= bias_mem[k_reg[KA-1:0]];
        shift_q_reg <= shift_mem[k_reg[KA-1:0]];
    end

    // Post-processing of the finished sum.
    logic [31:0] post_acc, rnd_acc, sh_acc;
    logic signed [33:0] v_val;
    logic [7:0]  post_res;
    logic [7:0]  w_diff;
    logic signed [16:0] prod;
    always_comb
    begin
        w_diff = wgt_q_reg - qcr_pkg::WEIGHT_ZERO;
        prod = $signed({1'b0, inside_q_reg ? pix_q_reg : 8'd0}) * $signed(w_diff);
        post_acc = acc_reg;
        if (cfg.post_flags[1])
            post_acc = post_acc + bias_q_reg;
        if (cfg.post_flags[0] && post_acc[31])
            post_acc = 32'd0;
        rnd_acc = post_acc;
        if (shift_q_reg != 5'd0)
            rnd_acc = post_acc + (32'd1 << (shift_q_reg - 5'd1));
        sh_acc = 32'($signed(rnd_acc) >>> shift_q_reg);
        v_val = 34'($signed(sh_acc)) + $signed(34'(cfg.output_offset));
        if (v_val > $signed(34'(qcr_pkg::BYTE_MAX)))
            post_res = 8'hFF;
        else if (v_val < 0)
            post_res = 8'd0;
        else
            post_res = v_val[7:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept && s_axis_tuser == qcr_pkg::REQ_COMPUTE)
                          state_next = ST_CHECK;
            ST_CHECK: state_next = (cfg_bad || req_bad) ? ST_OUT : ST_MAC;
            ST_MAC:   if (last_step) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_POST;
            ST_POST:  state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_MAC);
            if (state_reg == ST_OUT)
                valid_reg <= 1'b1;
            else if (m_axis_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_q_reg <= tap_in;
        if (accept)
        begin
            k_reg   <= kernel_sel;
            row_reg <= out_row;
            col_reg <= out_col;
        end
        unique case (state_reg)
            ST_CHECK:
            begin
                err_reg <= cfg_bad || req_bad;
                acc_reg <= 32'd0;
                c_reg   <= '0;
                r_reg   <= '0;
                s_reg   <= '0;
            end
            ST_MAC:
            begin
                if (5'(c_reg) == cfg.in_channels - 5'd1)
                begin
                    c_reg <= '0;
                    if (32'(s_reg) == 32'(KERNEL_COLS - 1))
                    begin
                        s_reg <= '0;
                        r_reg <= r_reg + 1'b1;
                    end
                    else
                        s_reg <= s_reg + 1'b1;
                end
                else
                    c_reg <= c_reg + 1'b1;
            end
            ST_POST:  res_reg <= post_res;
            ST_OUT:   if (err_reg) res_reg <= 8'd0;
            default:  ;
        endcase
        if (rd_valid_reg)
            acc_reg <= acc_reg + 32'(prod);
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = err_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |=> m_axis_tvalid)
        else $error("result not raised");
    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser == qcr_pkg::REQ_COMPUTE) |=> (state_reg == ST_CHECK))
        else $error("compute did not start");
`endif

endmodule

// ===== rtl/qcr_regs.sv =====
// Configuration register file of the quantized convolution block.
module qcr_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output qcr_pkg::cfg_t     cfg
);

    qcr_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_channels   <= 5'd1;
            cfg_reg.in_height     <= 6'd3;
            cfg_reg.in_width      <= 6'd3;
            cfg_reg.num_kernels   <= 5'd1;
            cfg_reg.pad_amount    <= 3'd0;
            cfg_reg.stride_step   <= 4'd1;
            cfg_reg.post_flags    <= 2'd0;
            cfg_reg.output_offset <= 8'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                qcr_pkg::CFG_CHANNELS: cfg_reg.in_channels   <= cfg_data[4:0];
                qcr_pkg::CFG_HEIGHT:   cfg_reg.in_height     <= cfg_data[5:0];
                qcr_pkg::CFG_WIDTH:    cfg_reg.in_width      <= cfg_data[5:0];
                qcr_pkg::CFG_KERNELS:  cfg_reg.num_kernels   <= cfg_data[4:0];
                qcr_pkg::CFG_PAD:      cfg_reg.pad_amount    <= cfg_data[2:0];
                qcr_pkg::CFG_STRIDE:   cfg_reg.stride_step   <= cfg_data[3:0];
                qcr_pkg::CFG_FLAGS:    cfg_reg.post_flags    <= cfg_data[1:0];
                qcr_pkg::CFG_OFFSET:   cfg_reg.output_offset <= cfg_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== verif/tb_quantized_conv2d_requant.sv =====
// Self-checking testbench of the quantized convolution block with requantization.
module tb_quantized_conv2d_requant;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH      = 16;
    localparam int N_DIM     = 32;
    localparam int N_KER     = 16;
    localparam int PIX_DEPTH = N_CH * N_DIM * N_DIM;
    localparam int WGT_DEPTH = N_KER * N_CH * 9;
    localparam int ITEM_GOAL = 1950;
    localparam int IDLE_LIMIT = 4000;

    typedef struct {
        logic [1:0]  typ;
        logic [13:0] addr;
        logic [7:0]  data;
        logic [31:0] bias;
        logic [4:0]  sh;
        logic [3:0]  ksel;
        logic [5:0]  row;
        logic [5:0]  col;
    } conv_req_t;

    typedef struct {
        logic [7:0] value;
        logic       err;
    } conv_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    quantized_conv2d_requant i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state, updated from accepted words only.
    qcr_pkg::cfg_t model_cfg;
    logic [7:0]  pix_mem [PIX_DEPTH];
    logic [7:0]  wgt_mem [WGT_DEPTH];
    logic [31:0] bias_mem [N_KER];
    logic [4:0]  shift_mem [N_KER];

    // Stimulus side: the settings in force and which entries hold data.
    qcr_pkg::cfg_t gen_cfg;
    bit   pix_loaded [PIX_DEPTH];
    bit   wgt_loaded [WGT_DEPTH];

    conv_req_t req_q [$];
    conv_res_t out_q [$];
    conv_req_t bus_req;
    logic      s_took = 1'b0;
    bit        no_idle = 1'b0;
    int        rx_hold = 0;
    int        n_items = 0;
    int        n_results = 0;
    int        n_err_results = 0;
    int        n_fail = 0;
    int        n_phases = 0;
    int        quiet_cycles = 0;

    function automatic conv_res_t predict_result(conv_req_t q);
        conv_res_t   res;
        int          ph, pw, oh, ow, y, x, st, pd;
        logic [31:0] acc, px, wx;
        logic [7:0]  w8;
        logic [4:0]  sh;
        longint      v;
        res.value = '0;
        res.err = 1'b1;
        if (model_cfg.in_channels == 0 || model_cfg.in_height < 3 || model_cfg.in_width < 3
            || model_cfg.num_kernels == 0 || model_cfg.stride_step == 0
            || model_cfg.in_channels > N_CH || model_cfg.num_kernels > N_KER
            || model_cfg.in_height > N_DIM || model_cfg.in_width > N_DIM)
            return res;
        st = int'(model_cfg.stride_step);
        pd = int'(model_cfg.pad_amount);
        ph = int'(model_cfg.in_height) + 2 * pd;
        pw = int'(model_cfg.in_width) + 2 * pd;
        oh = (ph - 3) / st + 1;
        ow = (pw - 3) / st + 1;
        if (q.ksel >= model_cfg.num_kernels || int'(q.row) >= oh || int'(q.col) >= ow)
            return res;
        acc = '0;
        for (int r = 0; r < 3; r++)
            for (int s = 0; s < 3; s++)
            begin
                y = int'(q.row) * st + r - pd;
                x = int'(q.col) * st + s - pd;
                for (int c = 0; c < int'(model_cfg.in_channels); c++)
                begin
                    px = '0;
                    if (y >= 0 && y < int'(model_cfg.in_height) && x >= 0
                        && x < int'(model_cfg.in_width))
                        px = {24'd0, pix_mem[(c * N_DIM + y) * N_DIM + x]};
                    w8 = wgt_mem[((int'(q.ksel) * N_CH + c) * 3 + r) * 3 + s]
                         - qcr_pkg::WEIGHT_ZERO;
                    wx = {{24{w8[7]}}, w8};
                    acc = acc + px * wx;
                end
            end
        if (model_cfg.post_flags[1])
            acc = acc + bias_mem[q.ksel];
        if (model_cfg.post_flags[0] && acc[31])
            acc = '0;
        sh = shift_mem[q.ksel];
        if (sh > 0)
            acc = acc + (32'd1 << (sh - 1));
        acc = $signed(acc) >>> sh;
        v = longint'($signed(acc)) + longint'(model_cfg.output_offset);
        if (v > longint'(qcr_pkg::BYTE_MAX))
            v = longint'(qcr_pkg::BYTE_MAX);
        else if (v < 0)
            v = 0;
        res.value = v[7:0];
        res.err = 1'b0;
        return res;
    endfunction

    function automatic void absorb_request(conv_req_t q);
        case (q.typ)
            qcr_pkg::REQ_PIXEL:   pix_mem[q.addr] = q.data;
            qcr_pkg::REQ_WEIGHT:  if (q.addr < WGT_DEPTH) wgt_mem[q.addr] = q.data;
            qcr_pkg::REQ_BIAS:
                if (q.addr < N_KER)
                begin
                    bias_mem[q.addr] = q.bias;
                    shift_mem[q.addr] = q.sh;
                end
            default:     out_q.push_back(predict_result(q));
        endcase
    endfunction

    // Sender.
    always @(negedge clk)
    begin
        if (!s_axis_tvalid || s_took)
        begin
            if (req_q.size() > 0 && (no_idle || $urandom_range(99) >= 24))
            begin
                bus_req = req_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= bus_req.typ;
                s_axis_tdata  <= {5'd0, bus_req.col, bus_req.row, bus_req.ksel, bus_req.sh,
                                  bus_req.bias, bus_req.data, bus_req.addr};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver, with its own count for the long hold-off.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= no_idle || $urandom_range(99) >= 24;
    end

    // Monitor of all three channels.
    always @(posedge clk)
    begin
        conv_res_t want;
        s_took <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            absorb_request(bus_req);
        if (cfg_valid && cfg_ready)
            case (cfg_index)
                qcr_pkg::CFG_CHANNELS: model_cfg.in_channels   = cfg_data[4:0];
                qcr_pkg::CFG_HEIGHT:   model_cfg.in_height     = cfg_data[5:0];
                qcr_pkg::CFG_WIDTH:    model_cfg.in_width      = cfg_data[5:0];
                qcr_pkg::CFG_KERNELS:  model_cfg.num_kernels   = cfg_data[4:0];
                qcr_pkg::CFG_PAD:      model_cfg.pad_amount    = cfg_data[2:0];
                qcr_pkg::CFG_STRIDE:   model_cfg.stride_step   = cfg_data[3:0];
                qcr_pkg::CFG_FLAGS:    model_cfg.post_flags    = cfg_data[1:0];
                default:               model_cfg.output_offset = cfg_data;
            endcase
        if (m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            if (out_q.size() == 0)
            begin
                n_fail++;
                $display("%0t: unexpected word value=%0d error=%0b", $time,
                         m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = out_q.pop_front();
                if (want.err)
                    n_err_results++;
                if (m_axis_tdata !== want.value)
                begin
                    n_fail++;
                    $display("%0t: out_value expected %0d actual %0d", $time,
                             want.value, m_axis_tdata);
                end
                if (m_axis_tuser !== want.err)
                begin
                    n_fail++;
                    $display("%0t: dim_error expected %0b actual %0b", $time,
                             want.err, m_axis_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("quantized_conv2d_requant: mismatch");
            $finish;
        end
    end

    task automatic push_req(conv_req_t q);
        req_q.push_back(q);
        n_items++;
    endtask

    function automatic conv_req_t rand_req(logic [1:0] typ);
        conv_req_t q;
        q.typ  = typ;
        q.addr = 14'($urandom);
        q.data = 8'($urandom);
        q.bias = $urandom;
        q.sh   = 5'($urandom);
        q.ksel = 4'($urandom);
        q.row  = 6'($urandom);
        q.col  = 6'($urandom);
        return q;
    endfunction

    task automatic load_pixel(int a, logic [7:0] d);
        conv_req_t q;
        q = rand_req(qcr_pkg::REQ_PIXEL);
        q.addr = 14'(a);
        q.data = d;
        pix_loaded[a] = 1'b1;
        push_req(q);
    endtask

    task automatic load_weight(int a, logic [7:0] d);
        conv_req_t q;
        q = rand_req(qcr_pkg::REQ_WEIGHT);
        q.addr = 14'(a);
        q.data = d;
        wgt_loaded[a] = 1'b1;
        push_req(q);
    endtask

    task automatic load_bias(int k, logic [31:0] b, logic [4:0] sh);
        conv_req_t q;
        q = rand_req(qcr_pkg::REQ_BIAS);
        q.addr = 14'(k);
        q.bias = b;
        q.sh = sh;
        push_req(q);
    endtask

    function automatic bit cfg_usable();
        return gen_cfg.in_channels != 0 && gen_cfg.in_channels <= N_CH
            && gen_cfg.in_height >= 3 && gen_cfg.in_height <= N_DIM
            && gen_cfg.in_width >= 3 && gen_cfg.in_width <= N_DIM
            && gen_cfg.num_kernels != 0 && gen_cfg.num_kernels <= N_KER
            && gen_cfg.stride_step != 0;
    endfunction

    function automatic int out_rows();
        return (int'(gen_cfg.in_height) + 2 * int'(gen_cfg.pad_amount) - 3)
               / int'(gen_cfg.stride_step) + 1;
    endfunction

    function automatic int out_cols();
        return (int'(gen_cfg.in_width) + 2 * int'(gen_cfg.pad_amount) - 3)
               / int'(gen_cfg.stride_step) + 1;
    endfunction

    // For a request in range, loads whatever the window still lacks, then asks for the output.
    task automatic ask_output(int k, int row, int col);
        conv_req_t q;
        int y, x, a, st, pd;
        if (cfg_usable() && k < int'(gen_cfg.num_kernels) && row < out_rows()
            && col < out_cols())
        begin
            st = int'(gen_cfg.stride_step);
            pd = int'(gen_cfg.pad_amount);
            for (int r = 0; r < 3; r++)
                for (int s = 0; s < 3; s++)
                    for (int c = 0; c < int'(gen_cfg.in_channels); c++)
                    begin
                        y = row * st + r - pd;
                        x = col * st + s - pd;
                        a = (c * N_DIM + y) * N_DIM + x;
                        if (y >= 0 && y < int'(gen_cfg.in_height) && x >= 0
                            && x < int'(gen_cfg.in_width) && !pix_loaded[a])
                            load_pixel(a, 8'($urandom));
                        a = ((k * N_CH + c) * 3 + r) * 3 + s;
                        if (!wgt_loaded[a])
                            load_weight(a, 8'($urandom));
                    end
        end
        q = rand_req(qcr_pkg::REQ_COMPUTE);
        q.ksel = 4'(k);
        q.row = 6'(row);
        q.col = 6'(col);
        push_req(q);
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (req_q.size() != 0 || s_axis_tvalid || out_q.size() != 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_regs(qcr_pkg::cfg_t c);
        logic [7:0] vals [8];
        vals = '{8'(c.in_channels), 8'(c.in_height), 8'(c.in_width), 8'(c.num_kernels),
                 8'(c.pad_amount), 8'(c.stride_step), 8'(c.post_flags), c.output_offset};
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            do @(posedge clk);
            while (!cfg_ready);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_cfg = c;
        n_phases++;
    endtask

    task automatic random_phase(int budget);
        int stop, roll, a, nch;
        conv_req_t q;
        stop = n_items + budget;
        nch = (gen_cfg.in_channels == 0) ? 1 : int'(gen_cfg.in_channels);
        while (n_items < stop)
        begin
            roll = $urandom_range(99);
            if (roll < 30)
            begin
                a = ($urandom_range(nch - 1) % N_CH * N_DIM + $urandom_range(N_DIM - 1))
                    * N_DIM + $urandom_range(N_DIM - 1);
                if ($urandom_range(1))
                    load_pixel(a, 8'($urandom));
                else
                    load_weight($urandom_range(WGT_DEPTH - 1), 8'($urandom));
            end
            else if (roll < 34)
                load_bias($urandom_range(N_KER - 1), $urandom, 5'($urandom));
            else if (roll < 38)
            begin
                q = rand_req(2'($urandom));
                if (q.typ == qcr_pkg::REQ_PIXEL)
                    pix_loaded[q.addr] = 1'b1;
                else if (q.typ == qcr_pkg::REQ_WEIGHT && q.addr < WGT_DEPTH)
                    wgt_loaded[q.addr] = 1'b1;
                else if (q.typ == qcr_pkg::REQ_COMPUTE)
                    q.typ = qcr_pkg::REQ_BIAS;
                push_req(q);
            end
            else if (roll < 44 || !cfg_usable())
                ask_output($urandom_range(15), $urandom_range(63), $urandom_range(63));
            else
                ask_output($urandom_range(int'(gen_cfg.num_kernels) - 1),
                           $urandom_range(out_rows() - 1), $urandom_range(out_cols() - 1));
        end
        wait_drained();
    endtask

    function automatic qcr_pkg::cfg_t rand_cfg();
        qcr_pkg::cfg_t c;
        c.in_channels   = 5'($urandom_range(1, 3));
        c.in_height     = 6'($urandom_range(3, 10));
        c.in_width      = 6'($urandom_range(3, 10));
        c.num_kernels   = 5'($urandom_range(1, 16));
        c.pad_amount    = 3'($urandom);
        c.stride_step   = 4'($urandom_range(1, 8));
        c.post_flags    = 2'($urandom);
        c.output_offset = 8'($urandom);
        return c;
    endfunction

    initial
    begin
        qcr_pkg::cfg_t c;
        conv_req_t q;
        model_cfg = '{5'd1, 6'd3, 6'd3, 5'd1, 3'd0, 4'd1, 2'd0, 8'd0};
        gen_cfg = model_cfg;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: default settings, then bias extremes and the rounding wrap.
        load_bias(0, 32'h8000_0000, 5'd0);
        load_bias(1, 32'h7fff_ffff, 5'd31);
        load_bias(2, 32'h7fff_ffff, 5'd31);
        for (int k = 3; k < N_KER; k++)
            load_bias(k, $urandom, 5'($urandom_range(1, 12)));
        ask_output(0, 0, 0);
        ask_output(1, 0, 0);
        ask_output(0, 1, 0);
        wait_drained();

        write_regs('{5'd1, 6'd3, 6'd3, 5'd16, 3'd1, 4'd1, 2'd2, 8'd128});
        for (int i = 0; i < 9; i++)
        begin
            load_pixel((i / 3) * N_DIM + i % 3, 8'd255);
            load_weight(2 * N_CH * 9 + i, 8'd255);
            load_weight(3 * N_CH * 9 + i, (i % 2) ? 8'd0 : 8'd127);
        end
        ask_output(2, 1, 1);
        ask_output(2, 0, 0);
        ask_output(3, 2, 2);
        ask_output(1, 1, 1);
        ask_output(0, 2, 0);
        ask_output(5, 3, 0);
        wait_drained();

        // Largest sizes, with only a few outputs.
        write_regs('{5'd16, 6'd32, 6'd32, 5'd16, 3'd7, 4'd8, 2'd3, 8'd255});
        ask_output(15, 0, 0);
        ask_output(15, 5, 5);
        ask_output(0, 2, 3);
        ask_output(0, 6, 0);
        wait_drained();

        // Settings that must flag a dimension error.
        write_regs('{5'd0, 6'd3, 6'd3, 5'd1, 3'd0, 4'd1, 2'd0, 8'd0});
        random_phase(15);
        write_regs('{5'd1, 6'd2, 6'd63, 5'd1, 3'd0, 4'd1, 2'd1, 8'd0});
        random_phase(15);
        write_regs('{5'd17, 6'd33, 6'd3, 5'd31, 3'd0, 4'd0, 2'd0, 8'd0});
        random_phase(15);
        write_regs('{5'd1, 6'd3, 6'd3, 5'd0, 3'd0, 4'd15, 2'd0, 8'd0});
        random_phase(15);

        // Receiver holds off while the sender keeps offering.
        write_regs(rand_cfg());
        rx_hold = 400;
        random_phase(60);

        no_idle = 1'b1;
        write_regs(rand_cfg());
        random_phase(150);
        no_idle = 1'b0;

        while (n_items < ITEM_GOAL)
        begin
            c = rand_cfg();
            if ($urandom_range(9) == 0)
                c.in_channels = 5'($urandom_range(4, 16));
            write_regs(c);
            random_phase((c.in_channels > 3) ? 40 : 120);
        end

        $display("Ran %0d request words over %0d register settings.", n_items, n_phases);
        $display("Checked %0d result words, %0d of them dimension errors.",
                 n_results, n_err_results);
        if (n_fail == 0 && out_q.size() == 0)
            $display("quantized_conv2d_requant: match");
        else
            $display("quantized_conv2d_requant: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/qcr_pkg.sv
rtl/qcr_regs.sv
rtl/quantized_conv2d_requant.sv
verif/tb_quantized_conv2d_requant.sv
